>>> design/asl_pkg.sv
// Shared types and codes for the active set list block.
`timescale 1ns / 1ps

package asl_pkg;

    localparam int CMD_W  = 3;
    localparam int ITEM_W = 12;
    localparam int KIND_W = 2;
    localparam int MARK_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LAZY_DEL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_IMM_DEL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ANIMATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIRTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;

    localparam logic [MARK_W-1:0] MARK_NONE    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_ACTIVE  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_PENDING = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ITEM_W-1:0] item_out;
        logic              last;
    } t_result;

endpackage

>>> design/asl_if.sv
// Command and result channel interfaces.
`timescale 1ns / 1ps

interface asl_cmd_if;
    import asl_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ITEM_W-1:0] item;
    logic              dirty_req;
    modport source (output valid, command, item, dirty_req, input ready);
    modport sink   (input valid, command, item, dirty_req, output ready);
endinterface

interface asl_res_if;
    import asl_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ITEM_W-1:0] item_out;
    logic              last;
    modport source (output valid, kind, item_out, last, input ready);
    modport sink   (input valid, kind, item_out, last, output ready);
endinterface

>>> design/asl_out_stage.sv
// Result output register that decouples the sequencer from the receiver.
`timescale 1ns / 1ps

module asl_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  asl_pkg::t_result i_res,
    asl_res_if.source        o_res
);
    import asl_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid    = r_valid;
    assign o_res.kind     = r_res.kind;
    assign o_res.item_out = r_res.item_out;
    assign o_res.last     = r_res.last;

endmodule

>>> design/active_set_list_lazy_delete.sv
// Active set list with lazy delete: list and mark memories under one sequencer.
//
// Commands arrive on i_cmd (valid/ready); each command is taken alone and
// i_cmd.ready stays low until its work is done. Results leave on o_res through
// a one-deep output register, with last set on the final result of a command.
// Command length is set by the single read port of the list memory and of the
// mark memory: every list entry visited costs one list read, and a tick adds
// one mark read and, for a dropped entry, one tail read per entry.
// Each result waits in the output register until taken; when the receiver
// stalls with a result still held, the sequencer holds at its next result.
// After reset the mark memory is swept to none, one entry a cycle, so the
// block takes no command until all ITEM_COUNT entries (4096 at the default) are swept.
// Clear walks only the listed entries: every item whose mark is not none is
// in the list, so clearing those marks clears them all.
`timescale 1ns / 1ps

module active_set_list_lazy_delete #(
    parameter int ITEM_COUNT = 4096,
    parameter int LIST_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asl_cmd_if.sink   i_cmd,
    asl_res_if.source o_res
);
    import asl_pkg::*;

    localparam int MW = $clog2(ITEM_COUNT);
    localparam int LW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LOOK = 4'd2;
    localparam logic [3:0] S_ADD  = 4'd3;
    localparam logic [3:0] S_LAZY = 4'd4;
    localparam logic [3:0] S_DEL  = 4'd5;
    localparam logic [3:0] S_TAIL = 4'd6;
    localparam logic [3:0] S_SRCH = 4'd7;
    localparam logic [3:0] S_TRD  = 4'd8;
    localparam logic [3:0] S_TMK  = 4'd9;
    localparam logic [3:0] S_TCHK = 4'd10;
    localparam logic [3:0] S_TSW  = 4'd11;
    localparam logic [3:0] S_TEND = 4'd12;
    localparam logic [3:0] S_CLR  = 4'd13;

    // control
    logic [3:0]        r_state, n_state;
    logic [MW-1:0]     r_init, n_init;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_cidx, n_cidx;
    logic              r_cv, n_cv;
    logic              r_pend_v, n_pend_v;
    logic              r_dirty, n_dirty;
    // payload
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [ITEM_W-1:0] r_item, n_item;
    logic [ITEM_W-1:0] r_e, n_e;
    logic [ITEM_W-1:0] r_tail, n_tail;
    logic [ITEM_W-1:0] r_pend, n_pend;

    // memories
    logic [MARK_W-1:0] r_mark_mem [ITEM_COUNT];
    logic [MARK_W-1:0] r_mark_rd;
    logic [ITEM_W-1:0] r_list_mem [LIST_DEPTH];
    logic [ITEM_W-1:0] r_list_rd;

    logic              w_mark_we;
    logic [MW-1:0]     w_mark_waddr;
    logic [MARK_W-1:0] w_mark_wdata;
    logic [MW-1:0]     w_mark_raddr;
    logic              w_list_we;
    logic [LW-1:0]     w_list_waddr;
    logic [ITEM_W-1:0] w_list_wdata;
    logic [LW-1:0]     w_list_raddr;

    logic              w_emit;
    logic              w_can_emit;
    t_result           w_res;

    logic              w_accept;
    logic              w_in_ok;
    logic              w_lrd_ok;
    logic              w_e_ok;
    logic              w_full;
    logic [CW-1:0]     w_last_pos;
    logic [MW+ITEM_W-1:0] w_item_x, w_lrd_x, w_e_x;
    logic [MW-1:0]     w_item_addr, w_lrd_addr, w_e_addr;

    assign w_item_x    = {{MW{1'b0}}, r_item};
    assign w_lrd_x     = {{MW{1'b0}}, r_list_rd};
    assign w_e_x       = {{MW{1'b0}}, r_e};
    assign w_item_addr = w_item_x[MW-1:0];
    assign w_lrd_addr  = w_lrd_x[MW-1:0];
    assign w_e_addr    = w_e_x[MW-1:0];

    assign w_in_ok   = 32'(i_cmd.item) < 32'(ITEM_COUNT);
    assign w_lrd_ok  = 32'(r_list_rd) < 32'(ITEM_COUNT);
    assign w_e_ok    = 32'(r_e) < 32'(ITEM_COUNT);

    assign w_full     = (r_count == CW'(LIST_DEPTH));
    assign w_last_pos = r_count - 1'b1;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_count  = r_count;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_cv     = r_cv;
        n_pend_v = r_pend_v;
        n_dirty  = r_dirty;
        n_cmd    = r_cmd;
        n_item   = r_item;
        n_e      = r_e;
        n_tail   = r_tail;
        n_pend   = r_pend;

        w_mark_we    = 1'b0;
        w_mark_waddr = w_item_addr;
        w_mark_wdata = MARK_NONE;
        w_mark_raddr = w_item_addr;
        w_list_we    = 1'b0;
        w_list_waddr = r_idx[LW-1:0];
        w_list_wdata = r_item;
        w_list_raddr = r_idx[LW-1:0];

        w_emit         = 1'b0;
        w_res.kind     = KIND_ANIMATE;
        w_res.item_out = r_item;
        w_res.last     = 1'b0;

        unique case (r_state)
            S_INIT: begin
                w_mark_we    = 1'b1;
                w_mark_waddr = r_init;
                if (r_init == MW'(ITEM_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_init = r_init + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_cmd.command;
                    n_item   = i_cmd.item;
                    n_dirty  = i_cmd.dirty_req;
                    n_idx    = '0;
                    n_cv     = 1'b0;
                    n_pend_v = 1'b0;
                    unique case (i_cmd.command) inside
                        CMD_ADD, CMD_LAZY_DEL, CMD_IMM_DEL: begin
                            n_state = w_in_ok ? S_LOOK : S_IDLE;
                        end
                        CMD_TICK:  n_state = S_TRD;
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK: begin
                unique case (r_cmd)
                    CMD_ADD:      n_state = S_ADD;
                    CMD_LAZY_DEL: n_state = S_LAZY;
                    default:      n_state = S_DEL;
                endcase
            end
            S_ADD: begin
                if (r_dirty) begin
                    w_emit         = 1'b1;
                    w_res.kind     = KIND_DIRTY;
                    w_res.last     = !((r_mark_rd == MARK_NONE) && w_full);
                    if (w_can_emit) begin
                        n_dirty = 1'b0;
                    end
                end else if (r_mark_rd == MARK_ACTIVE) begin
                    n_state = S_IDLE;
                end else if (r_mark_rd == MARK_NONE) begin
                    if (w_full) begin
                        // drop the append, mark stays none
                        w_emit     = 1'b1;
                        w_res.kind = KIND_FULL;
                        w_res.last = 1'b1;
                        if (w_can_emit) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        w_list_we    = 1'b1;
                        w_list_waddr = r_count[LW-1:0];
                        w_list_wdata = r_item;
                        n_count      = r_count + 1'b1;
                        w_mark_we    = 1'b1;
                        w_mark_wdata = MARK_ACTIVE;
                        n_state      = S_IDLE;
                    end
                end else begin
                    // pending item is still listed: reactivate only
                    w_mark_we    = 1'b1;
                    w_mark_wdata = MARK_ACTIVE;
                    n_state      = S_IDLE;
                end
            end
            S_LAZY: begin
                if (r_mark_rd == MARK_ACTIVE) begin
                    w_mark_we    = 1'b1;
                    w_mark_wdata = MARK_PENDING;
                end
                n_state = S_IDLE;
            end
            S_DEL: begin
                if (r_mark_rd == MARK_NONE) begin
                    n_state = S_IDLE;
                end else begin
                    w_mark_we = 1'b1;
                    if (r_count == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the tail entry for the swap
                        w_list_raddr = w_last_pos[LW-1:0];
                        n_state      = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                n_tail  = r_list_rd;
                n_idx   = '0;
                n_cv    = 1'b0;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                if (r_cv && (r_list_rd == r_item)) begin
                    w_list_we    = 1'b1;
                    w_list_waddr = r_cidx[LW-1:0];
                    w_list_wdata = r_tail;
                    n_count      = r_count - 1'b1;
                    n_cv         = 1'b0;
                    n_state      = S_IDLE;
                end else if (r_idx < r_count) begin
                    w_list_raddr = r_idx[LW-1:0];
                    n_cidx       = r_idx;
                    n_cv         = 1'b1;
                    n_idx        = r_idx + 1'b1;
                end else begin
                    n_cv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_TRD: begin
                if (r_idx < r_count) begin
                    w_list_raddr = r_idx[LW-1:0];
                    n_state      = S_TMK;
                end else begin
                    n_state = S_TEND;
                end
            end
            S_TMK: begin
                n_e          = r_list_rd;
                w_mark_raddr = w_lrd_addr;
                n_state      = S_TCHK;
            end
            S_TCHK: begin
                w_mark_raddr = w_e_addr;
                if (w_e_ok && (r_mark_rd == MARK_ACTIVE)) begin
                    // hold each kept entry until the next one shows it is not last
                    if (r_pend_v) begin
                        w_emit         = 1'b1;
                        w_res.kind     = KIND_ANIMATE;
                        w_res.item_out = r_pend;
                        w_res.last     = 1'b0;
                        if (w_can_emit) begin
                            n_pend  = r_e;
                            n_idx   = r_idx + 1'b1;
                            n_state = S_TRD;
                        end
                    end else begin
                        n_pend_v = 1'b1;
                        n_pend   = r_e;
                        n_idx    = r_idx + 1'b1;
                        n_state  = S_TRD;
                    end
                end else begin
                    w_mark_we    = w_e_ok;
                    w_mark_waddr = w_e_addr;
                    w_list_raddr = w_last_pos[LW-1:0];
                    n_state      = S_TSW;
                end
            end
            S_TSW: begin
                // move the tail into this slot and re-check it
                w_list_we    = 1'b1;
                w_list_waddr = r_idx[LW-1:0];
                w_list_wdata = r_list_rd;
                n_count      = r_count - 1'b1;
                n_state      = S_TRD;
            end
            S_TEND: begin
                if (r_pend_v) begin
                    w_emit         = 1'b1;
                    w_res.kind     = KIND_ANIMATE;
                    w_res.item_out = r_pend;
                    w_res.last     = 1'b1;
                    if (w_can_emit) begin
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                if (r_cv) begin
                    w_mark_we    = w_lrd_ok;
                    w_mark_waddr = w_lrd_addr;
                end
                if (r_idx < r_count) begin
                    w_list_raddr = r_idx[LW-1:0];
                    n_cv         = 1'b1;
                    n_idx        = r_idx + 1'b1;
                end else begin
                    n_cv    = 1'b0;
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_cidx   <= '0;
            r_cv     <= 1'b0;
            r_pend_v <= 1'b0;
            r_dirty  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_cidx   <= n_cidx;
            r_cv     <= n_cv;
            r_pend_v <= n_pend_v;
            r_dirty  <= n_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_item <= n_item;
        r_e    <= n_e;
        r_tail <= n_tail;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (w_mark_we) begin
            r_mark_mem[w_mark_waddr] <= w_mark_wdata;
        end
        r_mark_rd <= r_mark_mem[w_mark_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_list_we) begin
            r_list_mem[w_list_waddr] <= w_list_wdata;
        end
        r_list_rd <= r_list_mem[w_list_raddr];
    end

    asl_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_emit),
        .o_ready (w_can_emit),
        .i_res   (w_res),
        .o_res   (o_res)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("list count above depth");

    // unused codes and out-of-range items finish in the transfer cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.command == CMD_TICK || i_cmd.command == CMD_CLEAR
            || (i_cmd.command <= CMD_IMM_DEL && w_in_ok))) |=> !i_cmd.ready)
        else $error("command port ready right after a transfer");

    a_count_grows_by_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > $past(r_count)) |->
            ($past(r_state) == S_ADD && r_count == $past(r_count) + 1'b1))
        else $error("list count grew outside an append");

    a_animate_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_res.kind == KIND_ANIMATE) |-> (r_cmd == CMD_TICK))
        else $error("animate result outside a tick");

endmodule

>>> tb/active_set_list_lazy_delete_test.sv
// Self-checking testbench for the active set list with lazy delete.
`timescale 1ns / 1ps

module active_set_list_lazy_delete_test;
    import asl_pkg::*;

    localparam int ITEM_COUNT   = 4096;
    localparam int LIST_DEPTH   = 64;
    localparam int POOL_SIZE    = 40;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 300;

    // codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // Mirror of the mark and list memories; predicts the results of each command.
    class asl_scoreboard;
        logic [MARK_W-1:0] marks [ITEM_COUNT];
        logic [ITEM_W-1:0] slots [LIST_DEPTH];
        int                listed;
        t_result           batch [$];
        t_result           due_results [$];
        int                failures;

        function new();
            foreach (marks[i]) marks[i] = MARK_NONE;
            listed   = 0;
            failures = 0;
        endfunction

        function void add_result(logic [KIND_W-1:0] kind, logic [ITEM_W-1:0] itm);
            t_result r;
            r.kind     = kind;
            r.item_out = itm;
            r.last     = 1'b0;
            batch = {batch, r};
        endfunction

        function void drop_slot(int pos);
            slots[pos] = slots[listed-1];
            listed--;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] itm,
                                   logic dirty);
            int                pos;
            logic [ITEM_W-1:0] e;
            batch.delete();
            case (cmd)
                CMD_ADD: begin
                    if (dirty) add_result(KIND_DIRTY, itm);
                    if (marks[itm] == MARK_NONE) begin
                        // drop the append on a full list, mark stays none
                        if (listed >= LIST_DEPTH) begin
                            add_result(KIND_FULL, itm);
                        end else begin
                            slots[listed] = itm;
                            listed++;
                            marks[itm] = MARK_ACTIVE;
                        end
                    end else if (marks[itm] == MARK_PENDING) begin
                        marks[itm] = MARK_ACTIVE;
                    end
                end
                CMD_LAZY_DEL: begin
                    if (marks[itm] == MARK_ACTIVE) marks[itm] = MARK_PENDING;
                end
                CMD_IMM_DEL: begin
                    if (marks[itm] != MARK_NONE) begin
                        marks[itm] = MARK_NONE;
                        for (pos = 0; pos < listed; pos++) begin
                            if (slots[pos] == itm) begin
                                drop_slot(pos);
                                break;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    pos = 0;
                    // re-check the entry moved into a freed slot
                    while (pos < listed) begin
                        e = slots[pos];
                        if (marks[e] != MARK_ACTIVE) begin
                            marks[e] = MARK_NONE;
                            drop_slot(pos);
                        end else begin
                            add_result(KIND_ANIMATE, e);
                            pos++;
                        end
                    end
                end
                CMD_CLEAR: begin
                    listed = 0;
                    foreach (marks[i]) marks[i] = MARK_NONE;
                end
                default: ;
            endcase
            if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
            due_results = {due_results, batch};
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10) $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [ITEM_W-1:0] itm,
                                   logic last);
            t_result want;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d item %0d last %0d",
                                 kind, itm, last));
                return;
            end
            want = due_results.pop_front();
            if (kind !== want.kind || itm !== want.item_out || last !== want.last)
                report($sformatf({"result mismatch: expected kind %0d item %0d last %0d,",
                                  " got kind %0d item %0d last %0d"},
                                 want.kind, want.item_out, want.last, kind, itm, last));
        endfunction

        function void check_leftovers();
            if (due_results.size() != 0)
                report($sformatf("%0d expected results never arrived", due_results.size()));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    asl_cmd_if cmd_if ();
    asl_res_if res_if ();

    active_set_list_lazy_delete #(
        .ITEM_COUNT(ITEM_COUNT),
        .LIST_DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    asl_scoreboard     sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                recv_hold;
    int                issued;
    logic [ITEM_W-1:0] item_pool [POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("active_set_list_lazy_delete verification failed");
                $finish;
            end
        end
    end

    // Result receiver: randomly stall, or hold off entirely on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold || !i_rst_n)
                res_if.ready = 1'b0;
            else
                res_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                sb.check_result(res_if.kind, res_if.item_out, res_if.last);
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one command and hold it until the transfer; valid stays high afterward
    // until the next falling edge decides on a new command or a gap.
    task automatic issue(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] itm, logic dirty);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid     = 1'b1;
        cmd_if.command   = cmd;
        cmd_if.item      = itm;
        cmd_if.dirty_req = dirty;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_command(cmd, itm, dirty);
        if (cmd <= CMD_CLEAR) issued++;
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
    endtask

    task automatic wait_results_done();
        go_idle();
        while (sb.due_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ITEM_W-1:0] pick_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return item_pool[$urandom_range(0, POOL_SIZE-1)];
        if (r < 85 && sb.listed > 0) return sb.slots[$urandom_range(0, sb.listed-1)];
        return ITEM_W'($urandom_range(0, ITEM_COUNT-1));
    endfunction

    // Add random items until the list is full, then push one to three more past it
    task automatic fill_list();
        while (sb.listed < LIST_DEPTH)
            issue(CMD_ADD, ITEM_W'($urandom_range(0, ITEM_COUNT-1)), $urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 3))
            issue(CMD_ADD, ITEM_W'($urandom_range(0, ITEM_COUNT-1)), coin());
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            fill_list();
            repeat ($urandom_range(0, 4)) issue(CMD_LAZY_DEL, pick_item(), coin());
            if ($urandom_range(0, 1)) issue(CMD_IMM_DEL, pick_item(), coin());
            issue($urandom_range(0, 2) == 0 ? CMD_CLEAR : CMD_TICK, pick_item(), 1'b0);
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 6)) issue(CMD_ADD, pick_item(), coin());
            repeat ($urandom_range(0, 3)) issue(CMD_LAZY_DEL, pick_item(), coin());
            if ($urandom_range(0, 3) == 0) issue(CMD_IMM_DEL, pick_item(), coin());
            if ($urandom_range(0, 5) == 0) issue(CMD_ADD, pick_item(), coin());
            issue(CMD_TICK, ITEM_W'($urandom_range(0, ITEM_COUNT-1)), coin());
        end else begin
            issue(CMD_W'($urandom_range(0, 7)), ITEM_W'($urandom_range(0, ITEM_COUNT-1)),
                  coin());
        end
    endtask

    task automatic run_phase(int n_items, int idle_pct, int stall_pct);
        int goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = issued + n_items;
        while (issued < goal) random_sequence();
        wait_results_done();
    endtask

    initial begin
        sb = new();
        foreach (item_pool[i]) item_pool[i] = ITEM_W'($urandom_range(0, ITEM_COUNT-1));
        item_pool[0] = '0;
        item_pool[1] = ITEM_W'(ITEM_COUNT-1);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold        = 1'b0;
        issued           = 0;
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.command   = CMD_ADD;
        cmd_if.item      = '0;
        cmd_if.dirty_req = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty tick, dirty marks, re-add of active and pending items,
        // swap-removal by tick and immediate delete, unused codes, clear.
        issue(CMD_TICK,     12'd0,    1'b0);
        issue(CMD_ADD,      12'd0,    1'b1);
        issue(CMD_ADD,      12'd4095, 1'b0);
        issue(CMD_ADD,      12'd0,    1'b1);
        issue(CMD_ADD,      12'd0,    1'b0);
        issue(CMD_LAZY_DEL, 12'd0,    1'b0);
        issue(CMD_LAZY_DEL, 12'd0,    1'b1);
        issue(CMD_ADD,      12'd4095, 1'b1);
        issue(CMD_ADD,      12'd0,    1'b0);
        issue(CMD_LAZY_DEL, 12'd4095, 1'b0);
        issue(CMD_TICK,     12'd4095, 1'b1);
        issue(CMD_ADD,      12'd2730, 1'b1);
        issue(CMD_ADD,      12'd1365, 1'b0);
        issue(CMD_IMM_DEL,  12'd0,    1'b0);
        issue(CMD_IMM_DEL,  12'd7,    1'b0);
        issue(CMD_LAZY_DEL, 12'd1365, 1'b0);
        issue(CMD_IMM_DEL,  12'd1365, 1'b0);
        issue(CMD_LAZY_DEL, 12'd9,    1'b0);
        issue(CMD_TICK,     12'd0,    1'b0);
        issue(CMD_SPARE_5,  12'd4095, 1'b1);
        issue(CMD_SPARE_6,  12'd0,    1'b0);
        issue(CMD_SPARE_7,  12'd2730, 1'b1);
        issue(CMD_CLEAR,    12'd0,    1'b0);
        issue(CMD_TICK,     12'd0,    1'b0);
        fill_list();
        issue(CMD_TICK,     12'd0,    1'b0);
        wait_results_done();

        // Hold the receiver off while full-list ticks keep coming, so the
        // output register fills and the command side stalls
        fork
            begin
                recv_hold = 1'b1;
                repeat (600) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                fill_list();
                repeat (3) issue(CMD_TICK, 12'd0, 1'b0);
            end
        join
        wait_results_done();

        run_phase(90, 0, 0);
        run_phase(90, 80, 0);
        run_phase(90, 0, 80);
        run_phase(90, 26, 26);

        go_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_leftovers();
        if (sb.failures == 0)
            $display("active_set_list_lazy_delete verification clean");
        else
            $display("active_set_list_lazy_delete verification failed");
        $finish;
    end

endmodule

>>> active_set_list_lazy_delete.f
design/asl_pkg.sv
design/asl_if.sv
design/asl_out_stage.sv
design/active_set_list_lazy_delete.sv
tb/active_set_list_lazy_delete_test.sv
